// File: hdl/sts_pkg.sv
package sts_pkg;

    localparam int MAX_KEYWORD_CHARS_DEF = 8;
    localparam int LENGTH_BITS_DEF       = 16;
    localparam int OUT_DEPTH             = 4;
    localparam logic [23:0] LINE_MAX     = 24'hFFFFFF;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } t_in_item;

    typedef struct packed {
        logic [6:0]  token_kind;
        logic [1:0]  error_kind;
        logic [31:0] start_offset;
        logic [15:0] token_length;
        logic [23:0] line_number;
        logic        last_of_run;
    } t_out_item;

    typedef enum logic [4:0] {
        M_IDLE, M_COMMENT, M_NUM, M_NUMDOT, M_FLOAT, M_IDENT, M_STR, M_RAW,
        M_PIPE, M_DOT, M_DOTDOT, M_DOLLAR, M_MINUS, M_EQ, M_BANG, M_LT, M_LTLT,
        M_GT, M_AMP
    } t_mode;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_UNTERM = 2'd1;
    localparam logic [1:0] ERR_UNEXP  = 2'd2;

    localparam logic [6:0] K_INT = 7'd0, K_FLOAT = 7'd1, K_STRING = 7'd2,
        K_RAW = 7'd3, K_TRUE = 7'd4, K_FALSE = 7'd5, K_NULL = 7'd6,
        K_IDENT = 7'd7, K_LET = 7'd8, K_MUT = 7'd9, K_FN = 7'd10, K_IF = 7'd11,
        K_ELSE = 7'd12, K_FOR = 7'd13, K_IN = 7'd14, K_WHILE = 7'd15,
        K_LOOP = 7'd16, K_BREAK = 7'd17, K_CONTINUE = 7'd18, K_RETURN = 7'd19,
        K_MATCH = 7'd20, K_TRY = 7'd21, K_CATCH = 7'd22, K_USE = 7'd23,
        K_ERRKW = 7'd24, K_PIPE = 7'd25, K_BPIPE = 7'd26, K_DOT = 7'd27,
        K_DOTDOT = 7'd28, K_DOTDOTLT = 7'd29, K_SPREAD = 7'd30, K_PLUS = 7'd31,
        K_MINUS = 7'd32, K_STAR = 7'd33, K_SLASH = 7'd34, K_PERCENT = 7'd35,
        K_EQ = 7'd36, K_NEQ = 7'd37, K_LT = 7'd38, K_GT = 7'd39, K_LTE = 7'd40,
        K_GTE = 7'd41, K_REGEX = 7'd42, K_AND = 7'd43, K_OR = 7'd44,
        K_NOT = 7'd45, K_ASSIGN = 7'd46, K_QUESTION = 7'd47, K_CARET = 7'd48,
        K_DOLLAR = 7'd49, K_FATARROW = 7'd50, K_ARROW = 7'd51, K_AMP = 7'd52,
        K_ANDAND = 7'd53, K_OROR = 7'd54, K_APPEND = 7'd55, K_TILDE = 7'd56,
        K_DOLLARLP = 7'd57, K_LTLP = 7'd58, K_HEREDOC = 7'd59,
        K_HEREDOCSTR = 7'd60, K_LPAREN = 7'd61, K_RPAREN = 7'd62,
        K_LBRACE = 7'd63, K_RBRACE = 7'd64, K_LBRACKET = 7'd65,
        K_RBRACKET = 7'd66, K_COMMA = 7'd67, K_COLON = 7'd68, K_SEMI = 7'd69,
        K_NEWLINE = 7'd70, K_EOF = 7'd71, K_ERROR = 7'd72;

    localparam int KW_COUNT = 23;

    localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
        "let", "mut", "fn", "if", "else", "for", "in", "while", "loop",
        "break", "continue", "return", "match", "try", "catch", "use",
        "error", "true", "false", "null", "and", "or", "not"};

    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd3, 4'd3, 4'd2, 4'd2, 4'd4, 4'd3, 4'd2, 4'd5, 4'd4, 4'd5, 4'd8,
        4'd6, 4'd5, 4'd3, 4'd5, 4'd3, 4'd5, 4'd4, 4'd5, 4'd4, 4'd3, 4'd2,
        4'd3};

    localparam logic [6:0] KW_KIND [KW_COUNT] = '{
        K_LET, K_MUT, K_FN, K_IF, K_ELSE, K_FOR, K_IN, K_WHILE, K_LOOP,
        K_BREAK, K_CONTINUE, K_RETURN, K_MATCH, K_TRY, K_CATCH, K_USE,
        K_ERRKW, K_TRUE, K_FALSE, K_NULL, K_AND, K_OR, K_NOT};

    // word: first eight bytes, first byte in the top byte, zero padded
    function automatic logic [6:0] kw_lookup(input logic [63:0] word,
                                             input logic [3:0] len);
        logic [6:0] k;
        k = K_IDENT;
        for (int i = 0; i < KW_COUNT; i++) begin
            if (len == KW_LEN[i] &&
                word == (KW_TEXT[i] << (8 * (8 - int'(KW_LEN[i])))))
                k = KW_KIND[i];
        end
        return k;
    endfunction

endpackage

// File: hdl/script_token_scanner.sv
// script_token_scanner
// Input channel (i_in_valid / o_in_ready / i_in_data): one source byte per
// item with an end flag; a zero byte also ends the source. Output channel
// (o_out_valid / i_out_ready / o_out_data): tokens with kind, error, start
// offset, length, line and a flag on the last token caused by an item.
// Each accepted item is scanned in the cycle it is taken; its zero to three
// tokens enter a four-entry output queue and are offered from the next cycle
// on, one per cycle while i_out_ready is high. Throughput is one item per
// cycle while the queue holds at most one token; ready drops while fewer
// than three entries are free, which is what stalls the input when the
// receiver holds ready low or when several tokens come out of one byte.
// Reset clears the scanner to idle at offset zero, line one, and empties the
// queue. After the end-of-file token items are still taken but ignored,
// until the next reset.
module script_token_scanner #(
    parameter int MAX_KEYWORD_CHARS = sts_pkg::MAX_KEYWORD_CHARS_DEF,
    parameter int LENGTH_BITS       = sts_pkg::LENGTH_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  sts_pkg::t_in_item i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output sts_pkg::t_out_item o_out_data
);

    localparam int DEPTH = sts_pkg::OUT_DEPTH;
    localparam int PW    = $clog2(DEPTH);

    sts_pkg::t_mode            r_mode, n_mode;
    logic [31:0]               r_offset, n_offset;
    logic [31:0]               r_tstart, n_tstart;
    logic [LENGTH_BITS-1:0]    r_tlen, n_tlen;
    logic [23:0]               r_line, n_line;
    logic [MAX_KEYWORD_CHARS-1:0][7:0] r_wbuf, n_wbuf;
    logic                      r_esc, n_esc;
    logic                      r_eof, n_eof;

    sts_pkg::t_out_item        r_fifo [DEPTH];
    logic [PW-1:0]             r_wp, r_rp;
    logic [PW:0]               r_count;

    sts_pkg::t_out_item        e_item [3];
    logic [1:0]                e_n;
    logic                      acc, pop;

    function automatic logic [LENGTH_BITS-1:0] f_inc(input logic [LENGTH_BITS-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    assign acc = i_in_valid && o_in_ready;
    assign pop = o_out_valid && i_out_ready;

    always_comb begin
        logic [7:0]  cb;
        logic        ce, cv, dg, al, idc, used, em, opm, hit, nl;
        logic [6:0]  ek, kx, kd;
        logic [1:0]  ee;
        logic [31:0] est;
        logic [15:0] elen;
        logic [63:0] w64;
        cb = i_in_data.in_byte;
        ce = i_in_data.end_of_input || (cb == 8'd0);
        cv = !ce;
        dg = cv && cb >= "0" && cb <= "9";
        al = cv && ((cb >= "a" && cb <= "z") || (cb >= "A" && cb <= "Z") || cb == "_");
        idc = al || dg || (cv && cb == "-");
        n_mode = r_mode; n_tstart = r_tstart; n_tlen = r_tlen; n_line = r_line;
        n_wbuf = r_wbuf; n_esc = r_esc; n_eof = r_eof;
        n_offset = (acc && !r_eof && !ce) ? r_offset + 32'd1 : r_offset;
        used = 1'b0;
        e_n = 2'd0;
        for (int k = 0; k < 3; k++) e_item[k] = '0;
        for (int it = 0; it < 3; it++) begin
            em = 1'b0; ek = sts_pkg::K_EOF; ee = sts_pkg::ERR_NONE;
            est = n_tstart; elen = 16'(n_tlen);
            opm = 1'b0; hit = 1'b0; kx = sts_pkg::K_EOF; kd = sts_pkg::K_EOF;
            nl = 1'b0;
            for (int j = 0; j < 8; j++) w64[63-8*j -: 8] = n_wbuf[j];
            if (!used) begin
                case (n_mode)
                    sts_pkg::M_COMMENT: begin
                        if (ce || cb == "\n") n_mode = sts_pkg::M_IDLE;
                        else used = 1'b1;
                    end
                    sts_pkg::M_NUM: begin
                        if (dg) begin
                            n_tlen = f_inc(n_tlen); used = 1'b1;
                        end else if (cv && cb == ".") begin
                            n_mode = sts_pkg::M_NUMDOT; used = 1'b1;
                        end else begin
                            em = 1'b1; ek = sts_pkg::K_INT; n_mode = sts_pkg::M_IDLE;
                        end
                    end
                    sts_pkg::M_NUMDOT: begin
                        if (dg) begin
                            n_tlen = f_inc(f_inc(n_tlen));
                            n_mode = sts_pkg::M_FLOAT; used = 1'b1;
                        end else begin
                            em = 1'b1; ek = sts_pkg::K_INT;
                            n_mode = sts_pkg::M_DOT;
                            n_tstart = r_offset - 32'd1;
                            n_tlen = LENGTH_BITS'(1);
                        end
                    end
                    sts_pkg::M_FLOAT: begin
                        if (dg) begin
                            n_tlen = f_inc(n_tlen); used = 1'b1;
                        end else begin
                            em = 1'b1; ek = sts_pkg::K_FLOAT; n_mode = sts_pkg::M_IDLE;
                        end
                    end
                    sts_pkg::M_IDENT: begin
                        if (idc) begin
                            for (int j = 0; j < MAX_KEYWORD_CHARS; j++)
                                if (n_tlen == LENGTH_BITS'(j)) n_wbuf[j] = cb;
                            n_tlen = f_inc(n_tlen); used = 1'b1;
                        end else begin
                            em = 1'b1;
                            ek = (n_tlen > LENGTH_BITS'(MAX_KEYWORD_CHARS)) ?
                                 sts_pkg::K_IDENT :
                                 sts_pkg::kw_lookup(w64, n_tlen[3:0]);
                            n_mode = sts_pkg::M_IDLE;
                        end
                    end
                    sts_pkg::M_STR, sts_pkg::M_RAW: begin
                        if (ce) begin
                            em = 1'b1; ek = sts_pkg::K_ERROR; ee = sts_pkg::ERR_UNTERM;
                            elen = 16'd19; n_esc = 1'b0; n_mode = sts_pkg::M_IDLE;
                        end else begin
                            used = 1'b1;
                            n_tlen = f_inc(n_tlen);
                            if (n_mode == sts_pkg::M_STR && n_esc) begin
                                n_esc = 1'b0; nl = 1'b1;
                            end else if (n_mode == sts_pkg::M_STR && cb == "\\") begin
                                n_esc = 1'b1;
                            end else if ((n_mode == sts_pkg::M_STR && cb == "\"") ||
                                         (n_mode == sts_pkg::M_RAW && cb == "'")) begin
                                em = 1'b1; elen = 16'(n_tlen);
                                ek = (n_mode == sts_pkg::M_STR) ? sts_pkg::K_STRING
                                                                : sts_pkg::K_RAW;
                                n_mode = sts_pkg::M_IDLE;
                            end else begin
                                nl = 1'b1;
                            end
                            if (nl && cb == "\n" && n_line != sts_pkg::LINE_MAX)
                                n_line = n_line + 24'd1;
                        end
                    end
                    sts_pkg::M_PIPE: begin
                        opm = 1'b1; kd = sts_pkg::K_PIPE;
                        if (cv && cb == ">") begin hit = 1'b1; kx = sts_pkg::K_BPIPE; end
                        else if (cv && cb == "|") begin hit = 1'b1; kx = sts_pkg::K_OROR; end
                    end
                    sts_pkg::M_DOT: begin
                        if (cv && cb == ".") begin
                            n_tlen = f_inc(n_tlen); n_mode = sts_pkg::M_DOTDOT; used = 1'b1;
                        end else begin
                            em = 1'b1; ek = sts_pkg::K_DOT; n_mode = sts_pkg::M_IDLE;
                        end
                    end
                    sts_pkg::M_DOTDOT: begin
                        opm = 1'b1; kd = sts_pkg::K_DOTDOT;
                        if (cv && cb == "<") begin hit = 1'b1; kx = sts_pkg::K_DOTDOTLT; end
                        else if (cv && cb == ".") begin hit = 1'b1; kx = sts_pkg::K_SPREAD; end
                    end
                    sts_pkg::M_DOLLAR: begin
                        opm = 1'b1; kd = sts_pkg::K_DOLLAR;
                        if (cv && cb == "(") begin hit = 1'b1; kx = sts_pkg::K_DOLLARLP; end
                    end
                    sts_pkg::M_MINUS: begin
                        opm = 1'b1; kd = sts_pkg::K_MINUS;
                        if (cv && cb == ">") begin hit = 1'b1; kx = sts_pkg::K_ARROW; end
                    end
                    sts_pkg::M_EQ: begin
                        opm = 1'b1; kd = sts_pkg::K_ASSIGN;
                        if (cv && cb == "=") begin hit = 1'b1; kx = sts_pkg::K_EQ; end
                        else if (cv && cb == "~") begin hit = 1'b1; kx = sts_pkg::K_REGEX; end
                        else if (cv && cb == ">") begin hit = 1'b1; kx = sts_pkg::K_FATARROW; end
                    end
                    sts_pkg::M_BANG: begin
                        opm = 1'b1; kd = sts_pkg::K_NOT;
                        if (cv && cb == "=") begin hit = 1'b1; kx = sts_pkg::K_NEQ; end
                    end
                    sts_pkg::M_LT: begin
                        if (cv && cb == "<") begin
                            n_tlen = f_inc(n_tlen); n_mode = sts_pkg::M_LTLT; used = 1'b1;
                        end else begin
                            opm = 1'b1; kd = sts_pkg::K_LT;
                            if (cv && cb == "=") begin hit = 1'b1; kx = sts_pkg::K_LTE; end
                            else if (cv && cb == "(") begin hit = 1'b1; kx = sts_pkg::K_LTLP; end
                        end
                    end
                    sts_pkg::M_LTLT: begin
                        opm = 1'b1; kd = sts_pkg::K_HEREDOC;
                        if (cv && cb == "<") begin hit = 1'b1; kx = sts_pkg::K_HEREDOCSTR; end
                    end
                    sts_pkg::M_GT: begin
                        opm = 1'b1; kd = sts_pkg::K_GT;
                        if (cv && cb == "=") begin hit = 1'b1; kx = sts_pkg::K_GTE; end
                        else if (cv && cb == ">") begin hit = 1'b1; kx = sts_pkg::K_APPEND; end
                    end
                    sts_pkg::M_AMP: begin
                        opm = 1'b1; kd = sts_pkg::K_AMP;
                        if (cv && cb == "&") begin hit = 1'b1; kx = sts_pkg::K_ANDAND; end
                    end
                    default: begin
                        n_mode = sts_pkg::M_IDLE;
                        used = 1'b1;
                        est = r_offset; elen = 16'd1;
                        if (ce) begin
                            em = 1'b1; ek = sts_pkg::K_EOF; elen = 16'd0; n_eof = 1'b1;
                        end else if (dg || al) begin
                            n_mode = dg ? sts_pkg::M_NUM : sts_pkg::M_IDENT;
                            n_tstart = r_offset; n_tlen = LENGTH_BITS'(1);
                            if (al) begin
                                n_wbuf = '0; n_wbuf[0] = cb;
                            end
                        end else begin
                            case (cb)
                                " ", "\t", "\r": ;
                                "#":  n_mode = sts_pkg::M_COMMENT;
                                "\"": begin n_mode = sts_pkg::M_STR; n_esc = 1'b0; end
                                "'":  n_mode = sts_pkg::M_RAW;
                                "|":  n_mode = sts_pkg::M_PIPE;
                                ".":  n_mode = sts_pkg::M_DOT;
                                "$":  n_mode = sts_pkg::M_DOLLAR;
                                "-":  n_mode = sts_pkg::M_MINUS;
                                "=":  n_mode = sts_pkg::M_EQ;
                                "!":  n_mode = sts_pkg::M_BANG;
                                "<":  n_mode = sts_pkg::M_LT;
                                ">":  n_mode = sts_pkg::M_GT;
                                "&":  n_mode = sts_pkg::M_AMP;
                                "\n": begin
                                    if (n_line != sts_pkg::LINE_MAX) n_line = n_line + 24'd1;
                                    em = 1'b1; ek = sts_pkg::K_NEWLINE;
                                end
                                "+": begin em = 1'b1; ek = sts_pkg::K_PLUS; end
                                "*": begin em = 1'b1; ek = sts_pkg::K_STAR; end
                                "/": begin em = 1'b1; ek = sts_pkg::K_SLASH; end
                                "%": begin em = 1'b1; ek = sts_pkg::K_PERCENT; end
                                "~": begin em = 1'b1; ek = sts_pkg::K_TILDE; end
                                "^": begin em = 1'b1; ek = sts_pkg::K_CARET; end
                                "?": begin em = 1'b1; ek = sts_pkg::K_QUESTION; end
                                "(": begin em = 1'b1; ek = sts_pkg::K_LPAREN; end
                                ")": begin em = 1'b1; ek = sts_pkg::K_RPAREN; end
                                "{": begin em = 1'b1; ek = sts_pkg::K_LBRACE; end
                                "}": begin em = 1'b1; ek = sts_pkg::K_RBRACE; end
                                "[": begin em = 1'b1; ek = sts_pkg::K_LBRACKET; end
                                "]": begin em = 1'b1; ek = sts_pkg::K_RBRACKET; end
                                ",": begin em = 1'b1; ek = sts_pkg::K_COMMA; end
                                ":": begin em = 1'b1; ek = sts_pkg::K_COLON; end
                                ";": begin em = 1'b1; ek = sts_pkg::K_SEMI; end
                                default: begin
                                    em = 1'b1; ek = sts_pkg::K_ERROR;
                                    ee = sts_pkg::ERR_UNEXP; elen = 16'd20;
                                end
                            endcase
                            if (n_mode != sts_pkg::M_IDLE && n_mode != sts_pkg::M_COMMENT) begin
                                n_tstart = r_offset; n_tlen = LENGTH_BITS'(1);
                            end
                        end
                    end
                endcase
                if (opm) begin
                    if (hit) begin
                        n_tlen = f_inc(n_tlen); used = 1'b1; ek = kx;
                    end else begin
                        ek = kd;
                    end
                    em = 1'b1; elen = 16'(n_tlen); n_mode = sts_pkg::M_IDLE;
                end
                if (em) begin
                    e_item[e_n].token_kind   = ek;
                    e_item[e_n].error_kind   = ee;
                    e_item[e_n].start_offset = est;
                    e_item[e_n].token_length = elen;
                    e_item[e_n].line_number  = n_line;
                    e_n = e_n + 2'd1;
                end
            end
        end
        if (!acc || r_eof) e_n = 2'd0;
        for (int k = 0; k < 3; k++) e_item[k].last_of_run = (2'(k) == e_n - 2'd1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= sts_pkg::M_IDLE;
            r_offset <= '0;
            r_tstart <= '0;
            r_tlen   <= '0;
            r_line   <= 24'd1;
            r_wbuf   <= '0;
            r_esc    <= 1'b0;
            r_eof    <= 1'b0;
            r_wp     <= '0;
            r_rp     <= '0;
            r_count  <= '0;
        end else begin
            if (acc && !r_eof) begin
                r_mode   <= n_mode;
                r_offset <= n_offset;
                r_tstart <= n_tstart;
                r_tlen   <= n_tlen;
                r_line   <= n_line;
                r_wbuf   <= n_wbuf;
                r_esc    <= n_esc;
                r_eof    <= n_eof;
            end
            r_wp    <= r_wp + PW'(e_n);
            r_rp    <= r_rp + PW'(pop);
            r_count <= r_count + (PW+1)'(e_n) - (PW+1)'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            if (k < int'(e_n)) begin
                r_fifo[r_wp + PW'(k)] <= e_item[k];
            end
        end
    end

    always_comb begin
        o_in_ready  = (r_count < (PW+1)'(DEPTH - 2));
        o_out_valid = (r_count != '0);
        o_out_data  = r_fifo[r_rp];
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (PW+1)'(DEPTH))
        else $error("output queue overflow");

    a_eof_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_eof && !pop |=> r_count == $past(r_count))
        else $error("token queued after end of file");

    a_offset_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && !r_eof && !i_in_data.end_of_input && i_in_data.in_byte != 8'd0
        |=> r_offset == $past(r_offset) + 32'd1)
        else $error("byte offset did not advance");

endmodule
